// ===== design/tlsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tlsa_pkg
// Shared types and constants of the texture layer slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsa_pkg;

   localparam int TEX_W       = 12;
   localparam int CNT_W       = 13;
   localparam int QUANT_W     = 7;
   localparam int CSR_INDEX_W = 4;
   localparam int DIV_STEPS   = QUANT_W;
   localparam int STEP_W      = 3;

   localparam logic [TEX_W-1:0]   TEX_MIN       = 12'd16;
   localparam logic [TEX_W-1:0]   TEX_MAX       = 12'd1024;
   localparam logic [QUANT_W-1:0] SQUARE_LIFT_Q = 7'(64 / 16);

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_DEPTH     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ARRAY_SUPPORT = 4'd1;

   localparam logic [CNT_W-1:0] MAX_DEPTH_RESET = 13'd2048;

   typedef enum logic [1:0] {
      ST_GRANTED  = 2'd0,
      ST_BAD_DIM  = 2'd1,
      ST_NO_ARRAY = 2'd2,
      ST_FULL     = 2'd3
   } tlsa_status_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic rd;
      logic commit;
      logic clr;
   } tlsa_cmd_type;

   typedef struct packed {
      logic reject;
      logic div_last;
      logic clr_last;
      logic out_free;
   } tlsa_sts_type;

endpackage

`default_nettype wire

// ===== design/texture_layer_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// texture_layer_slot_allocator
// Checks a texture size, picks its bucket and hands out the next free layer
// of that bucket from a per-bucket counter store.
//
//   channel | dir | payload (low bit up)                      | beat when
//   req     | in  | tdata: tex_width, tex_height               | tvalid & tready
//   rsp     | out | tdata: array_index, layer; tuser: status   | tvalid & tready
//   csr     | in  | csr_index, csr_data                        | valid & ready
//
// A valid size passes through 7 remainder steps of the bit-serial divider, one
// counter read and one commit; the next request is taken after that commit.
// A rejected size skips the divider and the counter read and goes to the commit.
// After reset a clearing pass writes all 4096 counters, one per cycle;
// req_tready stays low during the pass, csr writes are taken.
// A waiting result does not block intake; the commit waits until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_layer_slot_allocator
   import tlsa_pkg::*;
#(
   parameter int BUCKET_DIM = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [23:0]            req_tdata,  // tex_width, tex_height
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [23:0]                 rsp_tdata,  // array_index, layer
   output logic [1:0]                  rsp_tuser,  // status
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]       csr_data
);

   tlsa_cmd_type    cmd;
   tlsa_sts_type    sts;
   logic [TEX_W-1:0] rsp_index, rsp_layer;
   tlsa_status_type rsp_status;

   assign csr_ready = 1'b1;

   tlsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tlsa_dp #(
      .BUCKET_DIM (BUCKET_DIM)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .tex_width   (req_tdata[11:0]),
      .tex_height  (req_tdata[23:12]),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .array_index (rsp_index),
      .layer       (rsp_layer),
      .status      (rsp_status)
   );

   assign rsp_tdata = {rsp_layer, rsp_index};
   assign rsp_tuser = rsp_status;

   // intake closes after a request beat
   a_intake_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in flight");

   // no intake during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !req_tready)
      else $error("request intake during counter clear");

   // a commit never overwrites an untaken result
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("result overwritten before taken");

   // rejected results carry no bucket and no layer
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_BAD_DIM || rsp_tuser == ST_NO_ARRAY)
      |-> rsp_tdata == 24'd0)
      else $error("rejected result with nonzero payload");

endmodule

`default_nettype wire

// ===== design/tlsa_ram.sv =====
// ----------------------------------------------------------------------------
// tlsa_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsa_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/tlsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlsa_ctrl
// Sequencer: clearing pass, request intake, remainder steps, counter
// read and result commit.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsa_ctrl
   import tlsa_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire tlsa_sts_type sts,
   output tlsa_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_READ,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.reject) begin
               state_in = S_DONE;
            end else begin
               cmd.div_step = 1'b1;
               if (sts.div_last) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

`default_nettype wire

// ===== design/tlsa_dp.sv =====
// ----------------------------------------------------------------------------
// tlsa_dp
// Datapath: size checks, bit-serial remainder, bucket index, layer counter
// store, configuration registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsa_dp
   import tlsa_pkg::*;
#(
   parameter int BUCKET_DIM = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tlsa_cmd_type           cmd,
   output tlsa_sts_type                sts,
   input  wire logic [TEX_W-1:0]       tex_width,
   input  wire logic [TEX_W-1:0]       tex_height,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CNT_W-1:0]       csr_data,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [TEX_W-1:0]            array_index,
   output logic [TEX_W-1:0]            layer,
   output tlsa_status_type             status
);

   localparam logic [TEX_W-1:0] DIM_W  = TEX_W'(BUCKET_DIM);
   localparam int               ADDR_W = TEX_W;

   logic [CNT_W-1:0]   max_depth_ff;
   logic               array_support_ff;
   logic [QUANT_W-1:0] q_ff, r_ff, big_ff, small_ff, dvd_ff, rem_ff;
   logic               bad_ff, nosup_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [ADDR_W-1:0]  idx_ff, clr_addr_ff;
   logic               rsp_valid_ff;
   logic [TEX_W-1:0]   rsp_index_ff, rsp_layer_ff;
   tlsa_status_type    rsp_status_ff;

   logic               ok_w, ok_h;
   logic [QUANT_W-1:0] q_in, r_in;
   logic [QUANT_W:0]   trial;
   logic [QUANT_W-1:0] qa, ra;
   logic               div_zero;
   logic [5:0]         row_m1, col_m1;
   logic [ADDR_W-1:0]  idx_in;
   logic [CNT_W-1:0]   cnt;
   logic               grant;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [CNT_W-1:0]   ram_wdata;

   // size checks and quantized sides
   assign ok_w = (tex_width[3:0] == 4'd0) && (tex_width >= TEX_MIN) && (tex_width <= TEX_MAX);
   assign ok_h = (tex_height[3:0] == 4'd0) && (tex_height >= TEX_MIN)
                 && (tex_height <= TEX_MAX);
   assign q_in = tex_width[QUANT_W+3:4];
   assign r_in = tex_height[QUANT_W+3:4];

   // one restoring remainder step
   assign trial = {rem_ff, dvd_ff[QUANT_W-1]};

   // squaring, lift of small squares, bucket index
   always_comb begin
      div_zero = (rem_ff == '0);
      qa       = div_zero ? big_ff : q_ff;
      ra       = div_zero ? big_ff : r_ff;
      if ((qa == ra) && ((qa == 7'd1) || (qa == 7'd2))) begin
         qa = SQUARE_LIFT_Q;
         ra = SQUARE_LIFT_Q;
      end
      row_m1 = 6'(ra - 7'd1);
      col_m1 = 6'(qa - 7'd1);
      idx_in = ADDR_W'(TEX_W'(row_m1) * DIM_W) + ADDR_W'(col_m1);
   end

   assign grant     = (cnt < max_depth_ff);
   assign ram_we    = cmd.clr || (cmd.commit && !bad_ff && !nosup_ff && grant);
   assign ram_waddr = cmd.clr ? clr_addr_ff : idx_ff;
   assign ram_wdata = cmd.clr ? '0 : CNT_W'(cnt + 13'd1);

   tlsa_ram #(
      .WIDTH (CNT_W),
      .DEPTH (1 << ADDR_W)
   ) u_counts (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.rd),
      .raddr (idx_in),
      .rdata (cnt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_depth_ff     <= MAX_DEPTH_RESET;
         array_support_ff <= 1'b1;
         clr_addr_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == REG_MAX_DEPTH) begin
               max_depth_ff <= csr_data;
            end else if (csr_index == REG_ARRAY_SUPPORT) begin
               array_support_ff <= csr_data[0];
            end
         end
         if (cmd.clr) begin
            clr_addr_ff <= ADDR_W'(clr_addr_ff + 12'd1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff     <= q_in;
         r_ff     <= r_in;
         bad_ff   <= !(ok_w && ok_h);
         nosup_ff <= !array_support_ff;
         big_ff   <= (q_in >= r_in) ? q_in : r_in;
         small_ff <= (q_in >= r_in) ? r_in : q_in;
         dvd_ff   <= (q_in >= r_in) ? q_in : r_in;
         rem_ff   <= '0;
         step_ff  <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[QUANT_W-2:0], 1'b0};
         step_ff <= STEP_W'(step_ff + 3'd1);
         if (trial >= {1'b0, small_ff}) begin
            rem_ff <= QUANT_W'(trial - {1'b0, small_ff});
         end else begin
            rem_ff <= trial[QUANT_W-1:0];
         end
      end
      if (cmd.rd) begin
         idx_ff <= idx_in;
      end
      if (cmd.commit) begin
         if (bad_ff || nosup_ff) begin
            rsp_index_ff  <= '0;
            rsp_layer_ff  <= '0;
            rsp_status_ff <= bad_ff ? ST_BAD_DIM : ST_NO_ARRAY;
         end else if (grant) begin
            rsp_index_ff  <= idx_ff;
            rsp_layer_ff  <= cnt[TEX_W-1:0];
            rsp_status_ff <= ST_GRANTED;
         end else begin
            rsp_index_ff  <= idx_ff;
            rsp_layer_ff  <= '0;
            rsp_status_ff <= ST_FULL;
         end
      end
   end

   assign sts.reject   = bad_ff || nosup_ff;
   assign sts.div_last = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign sts.clr_last = (&clr_addr_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid  = rsp_valid_ff;
   assign array_index = rsp_index_ff;
   assign layer       = rsp_layer_ff;
   assign status      = rsp_status_ff;

endmodule

`default_nettype wire
